>>> rtl/ps2mt_pkg.sv
`timescale 1ns / 1ps

package ps2mt_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned SIZE_BITS      = 16;
  localparam int unsigned CFG_IDX_BITS   = 8;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned OUT_DATA_BITS  = 40;

  localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 16'd1024;
  localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 16'd768;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 8'd1;

  localparam logic [7:0] SYNC_MASK = 8'b0000_1000;

  typedef enum logic [1:0] {
    MODE_BYTE   = 2'd0,
    MODE_TAKE   = 2'd1,
    MODE_STATUS = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    PH_SYNC = 3'b001,
    PH_DX   = 3'b010,
    PH_DY   = 3'b100
  } phase_e;

  typedef struct packed {
    logic       is_take;
    logic       has_pkt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } cmd_t;

endpackage

>>> rtl/ps2_mouse_packet_tracker.sv
`timescale 1ns / 1ps
// ps2 mouse packet tracker
// input stream s_axis: tuser selects the request (0 byte from mouse, 1 take the
// framed packet, 2 read status, 3 ignored), tdata carries the mouse byte
// output stream m_axis: one item per take or status request, none for bytes;
// tuser is the packet valid flag, tdata the cursor position, buttons and flags
// config channel cfg_*: index 0 screen width, index 1 screen height, always ready;
// write only while no request is in flight
// a taken request is registered in the command queue, its result then in the output
// register; one request per cycle is sustained while m_axis accepts, set by the single
// add-and-clamp stage behind a two-entry command queue
// reset clears framing, cursor, buttons and flags and sets the screen to 1024x768
// when m_axis stalls the result holds, the queue fills and s_axis_tready drops
// once both queue entries are in use
module ps2_mouse_packet_tracker #(
  parameter int unsigned COORD_BITS = ps2mt_pkg::COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // data_byte
  input  logic [1:0]                         s_axis_tuser,  // mode
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // cursor_x, cursor_y, left_button, middle_button, right_button, x_overflow,
  // y_overflow, zero padding
  output logic [ps2mt_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  output logic                               m_axis_tuser,  // packet_valid
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ps2mt_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [ps2mt_pkg::SIZE_BITS-1:0]    cfg_data_i
);

  logic [ps2mt_pkg::SIZE_BITS-1:0] width_q, height_q;
  logic                            space, push, q_valid, pop;
  ps2mt_pkg::cmd_t                 push_cmd, head_cmd;
  logic [15:0]                     cur_x, cur_y;
  logic [2:0]                      buttons;
  logic [1:0]                      flags;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ps2mt_pkg::WIDTH_RESET;
      height_q <= ps2mt_pkg::HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == ps2mt_pkg::CFG_SCREEN_WIDTH) begin
        width_q <= cfg_data_i;
      end else if (cfg_index_i == ps2mt_pkg::CFG_SCREEN_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  ps2mt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .mode_i      (s_axis_tuser),
    .data_byte_i (s_axis_tdata),
    .space_i     (space),
    .in_ready_o  (s_axis_tready),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  ps2mt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .space_o (space),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  ps2mt_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .cmd_i          (head_cmd),
    .pop_o          (pop),
    .width_i        (width_q),
    .height_i       (height_q),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .packet_valid_o (m_axis_tuser),
    .cursor_x_o     (cur_x),
    .cursor_y_o     (cur_y),
    .buttons_o      (buttons),
    .flags_o        (flags)
  );

  assign m_axis_tdata = {3'b000, flags[1], flags[0], buttons[1], buttons[2], buttons[0],
                         cur_y, cur_x};

endmodule

>>> rtl/ps2mt_front.sv
`timescale 1ns / 1ps

module ps2mt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       mode_i,
  input  logic [7:0]       data_byte_i,
  input  logic             space_i,
  output logic             in_ready_o,
  output logic             push_o,
  output ps2mt_pkg::cmd_t  cmd_o
);

  ps2mt_pkg::phase_e phase_q, phase_d;
  logic              pending_q, pending_d;
  logic [7:0]        b0_q, b1_q, b2_q;
  logic              fire;

  assign in_ready_o = space_i;
  assign fire       = in_valid_i & space_i;

  always_comb begin
    phase_d   = phase_q;
    pending_d = pending_q;
    push_o    = 1'b0;
    cmd_o     = '{is_take: 1'b0, has_pkt: 1'b0, b0: b0_q, b1: b1_q, b2: b2_q};
    if (fire) begin
      case (mode_i)
        ps2mt_pkg::MODE_BYTE: begin
          if (!pending_q) begin
            case (phase_q)
              ps2mt_pkg::PH_DX: phase_d = ps2mt_pkg::PH_DY;
              ps2mt_pkg::PH_DY: begin
                phase_d   = ps2mt_pkg::PH_SYNC;
                pending_d = 1'b1;
              end
              default: begin
                if ((data_byte_i & ps2mt_pkg::SYNC_MASK) != 8'd0) begin
                  phase_d = ps2mt_pkg::PH_DX;
                end
              end
            endcase
          end
        end
        ps2mt_pkg::MODE_TAKE: begin
          push_o        = 1'b1;
          cmd_o.is_take = 1'b1;
          cmd_o.has_pkt = pending_q;
          pending_d     = 1'b0;
        end
        ps2mt_pkg::MODE_STATUS: begin
          push_o = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ps2mt_pkg::PH_SYNC;
      pending_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      pending_q <= pending_d;
    end
  end

  // packet bytes
  always_ff @(posedge clk_i) begin
    if (fire && mode_i == ps2mt_pkg::MODE_BYTE && !pending_q) begin
      case (phase_q)
        ps2mt_pkg::PH_DX: b1_q <= data_byte_i;
        ps2mt_pkg::PH_DY: b2_q <= data_byte_i;
        default:          b0_q <= data_byte_i;
      endcase
    end
  end

endmodule

>>> rtl/ps2mt_queue.sv
`timescale 1ns / 1ps

module ps2mt_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ps2mt_pkg::cmd_t  cmd_i,
  output logic             space_o,
  input  logic             pop_i,
  output logic             valid_o,
  output ps2mt_pkg::cmd_t  cmd_o
);

  localparam int unsigned PtrBits = $clog2(ps2mt_pkg::QUEUE_DEPTH);
  localparam int unsigned CntBits = $clog2(ps2mt_pkg::QUEUE_DEPTH + 1);

  ps2mt_pkg::cmd_t      slot_q [ps2mt_pkg::QUEUE_DEPTH];
  logic [PtrBits-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;

  assign space_o = cnt_q != CntBits'(ps2mt_pkg::QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = slot_q[rd_q];

  function automatic logic [PtrBits-1:0] bump(input logic [PtrBits-1:0] p);
    if (p == PtrBits'(ps2mt_pkg::QUEUE_DEPTH - 1)) begin
      bump = '0;
    end else begin
      bump = p + 1'b1;
    end
  endfunction

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = bump(wr_q);
    end
    if (pop_i) begin
      rd_d = bump(rd_q);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

endmodule

>>> rtl/ps2mt_back.sv
`timescale 1ns / 1ps

module ps2mt_back #(
  parameter int unsigned COORD_BITS = ps2mt_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  ps2mt_pkg::cmd_t                 cmd_i,
  output logic                            pop_o,
  input  logic [ps2mt_pkg::SIZE_BITS-1:0] width_i,
  input  logic [ps2mt_pkg::SIZE_BITS-1:0] height_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            packet_valid_o,
  output logic [15:0]                     cursor_x_o,
  output logic [15:0]                     cursor_y_o,
  output logic [2:0]                      buttons_o,
  output logic [1:0]                      flags_o
);

  localparam int unsigned SumBits = COORD_BITS + 3;
  localparam int unsigned SzBits  = ps2mt_pkg::SIZE_BITS;

  logic [COORD_BITS-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [2:0]            btn_q, btn_d;
  logic [1:0]            flg_q, flg_d;
  logic                  ov_q;
  logic                  pv_q, pv_d;
  logic [15:0]           ox_q, ox_d, oy_q, oy_d;
  logic [2:0]            ob_q, ob_d;
  logic [1:0]            of_q, of_d;
  logic signed [10:0]    dx, dy;
  logic signed [SumBits-1:0] sum_x, sum_y;

  function automatic logic signed [10:0] delta(input logic [7:0] mag, input logic sgn,
                                               input logic ovf);
    logic signed [10:0] d;
    d = $signed({3'b000, mag});
    if (sgn) begin
      d = d - 11'sd256;
    end
    if (ovf) begin
      d = sgn ? d - 11'sd256 : d + 11'sd256;
    end
    delta = d;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SumBits-1:0] v,
                                                  input logic [SzBits-1:0] size);
    logic [SzBits-1:0]     lim;
    logic [COORD_BITS-1:0] top;
    lim = size - 1'b1;
    top = ((lim >> COORD_BITS) != '0) ? '1 : lim[COORD_BITS-1:0];
    if (size == '0) begin
      clamp = '0;
    end else if (v < 0) begin
      clamp = '0;
    end else if (v > $signed(SumBits'(top))) begin
      clamp = top;
    end else begin
      clamp = v[COORD_BITS-1:0];
    end
  endfunction

  assign pop_o = q_valid_i & (~ov_q | out_ready_i);

  always_comb begin
    dx    = delta(cmd_i.b1, cmd_i.b0[4], cmd_i.b0[6]);
    dy    = delta(cmd_i.b2, cmd_i.b0[5], cmd_i.b0[7]);
    sum_x = $signed(SumBits'(pos_x_q)) + SumBits'(dx);
    sum_y = $signed(SumBits'(pos_y_q)) - SumBits'(dy);

    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    btn_d   = btn_q;
    flg_d   = flg_q;
    if (cmd_i.is_take && cmd_i.has_pkt) begin
      pos_x_d = clamp(sum_x, width_i);
      pos_y_d = clamp(sum_y, height_i);
      btn_d   = cmd_i.b0[2:0];
      flg_d   = cmd_i.b0[7:6];
    end

    if (cmd_i.is_take && !cmd_i.has_pkt) begin
      pv_d = 1'b0;
      ox_d = '0;
      oy_d = '0;
      ob_d = '0;
      of_d = '0;
    end else begin
      pv_d = 1'b1;
      ox_d = 16'(pos_x_d);
      oy_d = 16'(pos_y_d);
      ob_d = btn_d;
      of_d = flg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      btn_q   <= '0;
      flg_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (pop_o) begin
        pos_x_q <= pos_x_d;
        pos_y_q <= pos_y_d;
        btn_q   <= btn_d;
        flg_q   <= flg_d;
        ov_q    <= 1'b1;
      end else if (out_ready_i) begin
        ov_q    <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pv_q <= pv_d;
      ox_q <= ox_d;
      oy_q <= oy_d;
      ob_q <= ob_d;
      of_q <= of_d;
    end
  end

  assign out_valid_o    = ov_q;
  assign packet_valid_o = pv_q;
  assign cursor_x_o     = ox_q;
  assign cursor_y_o     = oy_q;
  assign buttons_o      = ob_q;
  assign flags_o        = of_q;

endmodule
